// File: hw/rtl/jsp_pkg.sv
package jsp_pkg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_DIRECT = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        REG_DEAD_ZONE   = 3'd0,
        REG_STEP_SIZE   = 3'd1,
        REG_PITCH_LOW   = 3'd2,
        REG_PITCH_HIGH  = 3'd3,
        REG_YAW_LOW     = 3'd4,
        REG_YAW_HIGH    = 3'd5
    } t_reg_idx;

    // what one axis lane hands on to the output stage
    typedef struct packed {
        logic [7:0] angle;
        logic       written;
    } t_lane_result;

    localparam logic [7:0]  STICK_CENTRE    = 8'd128;
    localparam logic [7:0]  HOME_ANGLE      = 8'd90;
    localparam logic [7:0]  MAX_ANGLE       = 8'd180;
    localparam logic [11:0] CMP_BASE        = 12'd500;
    localparam logic [11:0] CMP_TOP         = 12'd2500;
    // 100/9 scaled by 2^16, rounded up; exact floor for angles up to 180
    localparam logic [19:0] CMP_RECIP       = 20'd728200;
    localparam int          CMP_SHIFT       = 16;
    localparam logic [7:0]  DEAD_ZONE_RST   = 8'd15;
    localparam logic [7:0]  STEP_SIZE_RST   = 8'd2;
    localparam logic [7:0]  LIMIT_LOW_RST   = 8'd0;
    localparam logic [7:0]  LIMIT_HIGH_RST  = 8'd180;

endpackage

// File: hw/rtl/jsp_axis_lane.sv
module jsp_axis_lane #(
    parameter int FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_opcode,
    input  logic signed [8:0]        i_x,
    input  logic                     i_start,
    input  logic [7:0]               i_request,
    input  logic [7:0]               i_dead_zone,
    input  logic [7:0]               i_step_size,
    input  logic [7:0]               i_low,
    input  logic [7:0]               i_high,
    output jsp_pkg::t_lane_result    o_result
);

    // filter spans [-128, 128] in whole units plus sign
    localparam int FW = FRAC_BITS + 9;

    logic signed [FW-1:0] r_filter;
    logic signed [FW-1:0] n_filter;
    logic [7:0]           r_target;
    logic [7:0]           n_target;
    logic                 r_written;

    logic signed [FW-1:0] w_xq;
    logic signed [FW-1:0] w_fq;
    logic [FW-1:0]        w_mag;
    logic [FW-1:0]        w_dz_scaled;
    logic                 w_move;
    logic signed [9:0]    w_stepped;

    function automatic logic [7:0] clamp_angle(input logic signed [9:0] a,
                                               input logic [7:0] lo,
                                               input logic [7:0] hi);
        logic signed [9:0] v;
        begin
            v = a;
            if (v < $signed({2'b00, lo})) v = $signed({2'b00, lo});
            if (v > $signed({2'b00, hi})) v = $signed({2'b00, hi});
            clamp_angle = v[7:0];
        end
    endfunction

    // x/4 of the scaled sample is exact, f/4 floors
    assign w_xq     = FW'(i_x) <<< (FRAC_BITS - 2);
    assign w_fq     = r_filter >>> 2;
    assign n_filter = r_filter - w_fq + w_xq;

    assign w_mag       = n_filter[FW-1] ? FW'(-n_filter) : FW'(n_filter);
    assign w_dz_scaled = FW'(i_dead_zone) << FRAC_BITS;
    assign w_move      = (w_mag > w_dz_scaled) && (w_mag[FW-1:FRAC_BITS] != '0);

    always_comb begin
        w_stepped = $signed({2'b00, r_target});
        if (w_move) begin
            if (n_filter[FW-1]) begin
                w_stepped = $signed({2'b00, r_target}) - $signed({2'b00, i_step_size});
            end else begin
                w_stepped = $signed({2'b00, r_target}) + $signed({2'b00, i_step_size});
            end
        end
    end

    always_comb begin
        if (i_opcode == jsp_pkg::OP_DIRECT) begin
            n_target = clamp_angle($signed({2'b00, i_request}), i_low, i_high);
        end else if (i_start) begin
            n_target = jsp_pkg::HOME_ANGLE;
        end else begin
            n_target = clamp_angle(w_stepped, i_low, i_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter  <= '0;
            r_target  <= jsp_pkg::HOME_ANGLE;
            r_written <= 1'b0;
        end else if (i_accept) begin
            if (i_opcode == jsp_pkg::OP_SAMPLE) begin
                r_filter <= n_filter;
            end
            r_target  <= n_target;
            r_written <= (n_target != r_target);
        end
    end

    assign o_result.angle   = r_target;
    assign o_result.written = r_written;

`ifndef SYNTHESIS
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_target) && $stable(r_filter))
        else $error("lane state moved without a request");

    a_direct_keeps_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_opcode == jsp_pkg::OP_DIRECT) |=> $stable(r_filter))
        else $error("direct set disturbed the filter");

    a_written_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_written == (r_target != $past(r_target))))
        else $error("written flag disagrees with target change");
`endif

endmodule

// File: hw/rtl/jsp_merge.sv
module jsp_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  jsp_pkg::t_lane_result i_pitch,
    input  jsp_pkg::t_lane_result i_yaw,
    output logic                  o_ready,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [7:0]            o_pitch_angle,
    output logic [7:0]            o_yaw_angle,
    output logic [11:0]           o_pitch_compare,
    output logic [11:0]           o_yaw_compare,
    output logic                  o_pitch_written,
    output logic                  o_yaw_written
);

    logic        r_valid;
    logic [7:0]  r_pitch_angle;
    logic [7:0]  r_yaw_angle;
    logic [11:0] r_pitch_compare;
    logic [11:0] r_yaw_compare;
    logic        r_pitch_written;
    logic        r_yaw_written;
    logic        w_take;

    // 500 + v*2000/180, v saturated at 180
    function automatic logic [11:0] angle_to_compare(input logic [7:0] a);
        logic [7:0]  v;
        logic [27:0] prod;
        begin
            v    = (a > jsp_pkg::MAX_ANGLE) ? jsp_pkg::MAX_ANGLE : a;
            prod = 28'(v) * 28'(jsp_pkg::CMP_RECIP);
            angle_to_compare = jsp_pkg::CMP_BASE + prod[jsp_pkg::CMP_SHIFT +: 12];
        end
    endfunction

    assign o_ready = !r_valid || !i_stall;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pitch_angle   <= i_pitch.angle;
            r_yaw_angle     <= i_yaw.angle;
            r_pitch_compare <= angle_to_compare(i_pitch.angle);
            r_yaw_compare   <= angle_to_compare(i_yaw.angle);
            r_pitch_written <= i_pitch.written;
            r_yaw_written   <= i_yaw.written;
        end
    end

    assign o_valid         = r_valid;
    assign o_pitch_angle   = r_pitch_angle;
    assign o_yaw_angle     = r_yaw_angle;
    assign o_pitch_compare = r_pitch_compare;
    assign o_yaw_compare   = r_yaw_compare;
    assign o_pitch_written = r_pitch_written;
    assign o_yaw_written   = r_yaw_written;

`ifndef SYNTHESIS
    a_compare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_compare >= jsp_pkg::CMP_BASE) &&
                    (o_pitch_compare <= jsp_pkg::CMP_TOP) &&
                    (o_yaw_compare >= jsp_pkg::CMP_BASE) &&
                    (o_yaw_compare <= jsp_pkg::CMP_TOP))
        else $error("servo compare out of range");

    a_compare_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pitch_angle >= jsp_pkg::MAX_ANGLE) |->
            (o_pitch_compare == jsp_pkg::CMP_TOP))
        else $error("pitch compare not saturated at full angle");
`endif

endmodule

// File: hw/rtl/joystick_to_servo_pan_tilt.sv
// Joystick to pan/tilt servo controller.
// Input channel (i_valid / o_stall): one request per item. Opcode 0 carries a
// joystick sample; both axes are low-pass filtered in parallel lanes, step
// their target angle when outside the dead zone, and are clamped to limits.
// Start recentres both targets to 90. Opcode 1 sets the angles directly.
// Output channel (o_valid / i_stall): one result per request with both
// angles, servo compare values (500..2500 us) and changed flags.
// Pipeline: a result passes the lane register, then the output register
// that holds the compare scaling.
// Throughput: one request per cycle while o_stall is low; filter and angle
// updates are computed combinationally inside each lane.
// Stall: a stalled result holds in the output register; the lane stage
// still takes one more request, after which o_stall rises until the
// receiver drains.
// Reset (synchronous, active low): filters clear, angles go to 90, limits to
// 0..180, dead zone 15, step 2. The user writes registers over the APB port
// only while the block is idle; the block itself does not enforce it.
module joystick_to_servo_pan_tilt #(
    parameter int FILTER_FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_stick_vertical,
    input  logic [7:0]  i_stick_horizontal,
    input  logic        i_start_pressed,
    input  logic [7:0]  i_request_pitch,
    input  logic [7:0]  i_request_yaw,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pitch_angle,
    output logic [7:0]  o_yaw_angle,
    output logic [11:0] o_pitch_compare,
    output logic [11:0] o_yaw_compare,
    output logic        o_pitch_written,
    output logic        o_yaw_written,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_dead_zone;
    logic [7:0] r_step_size;
    logic [7:0] r_pitch_low;
    logic [7:0] r_pitch_high;
    logic [7:0] r_yaw_low;
    logic [7:0] r_yaw_high;

    logic       r_s1_valid;
    logic       w_merge_ready;
    logic       w_accept;
    logic       w_cfg_write;
    logic [2:0] w_reg_idx;

    logic signed [8:0] w_x_pitch;
    logic signed [8:0] w_x_yaw;

    jsp_pkg::t_lane_result w_pitch_res;
    jsp_pkg::t_lane_result w_yaw_res;

    // configuration port
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_reg_idx   = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= jsp_pkg::DEAD_ZONE_RST;
            r_step_size  <= jsp_pkg::STEP_SIZE_RST;
            r_pitch_low  <= jsp_pkg::LIMIT_LOW_RST;
            r_pitch_high <= jsp_pkg::LIMIT_HIGH_RST;
            r_yaw_low    <= jsp_pkg::LIMIT_LOW_RST;
            r_yaw_high   <= jsp_pkg::LIMIT_HIGH_RST;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                jsp_pkg::REG_DEAD_ZONE:  r_dead_zone  <= pwdata[7:0];
                jsp_pkg::REG_STEP_SIZE:  r_step_size  <= pwdata[7:0];
                jsp_pkg::REG_PITCH_LOW:  r_pitch_low  <= pwdata[7:0];
                jsp_pkg::REG_PITCH_HIGH: r_pitch_high <= pwdata[7:0];
                jsp_pkg::REG_YAW_LOW:    r_yaw_low    <= pwdata[7:0];
                jsp_pkg::REG_YAW_HIGH:   r_yaw_high   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            jsp_pkg::REG_DEAD_ZONE:  prdata = {24'd0, r_dead_zone};
            jsp_pkg::REG_STEP_SIZE:  prdata = {24'd0, r_step_size};
            jsp_pkg::REG_PITCH_LOW:  prdata = {24'd0, r_pitch_low};
            jsp_pkg::REG_PITCH_HIGH: prdata = {24'd0, r_pitch_high};
            jsp_pkg::REG_YAW_LOW:    prdata = {24'd0, r_yaw_low};
            jsp_pkg::REG_YAW_HIGH:   prdata = {24'd0, r_yaw_high};
            default:                 prdata = 32'd0;
        endcase
    end

    // lane stage advances when empty or when the output stage takes it
    assign o_stall  = r_s1_valid && !w_merge_ready;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_merge_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    // centred sticks: up and right are positive
    assign w_x_pitch = $signed({1'b0, jsp_pkg::STICK_CENTRE}) - $signed({1'b0, i_stick_vertical});
    assign w_x_yaw   = $signed({1'b0, i_stick_horizontal}) - $signed({1'b0, jsp_pkg::STICK_CENTRE});

    jsp_axis_lane #(
        .FRAC_BITS (FILTER_FRACTION_BITS)
    ) u_pitch_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_opcode    (i_opcode),
        .i_x         (w_x_pitch),
        .i_start     (i_start_pressed),
        .i_request   (i_request_pitch),
        .i_dead_zone (r_dead_zone),
        .i_step_size (r_step_size),
        .i_low       (r_pitch_low),
        .i_high      (r_pitch_high),
        .o_result    (w_pitch_res)
    );

    jsp_axis_lane #(
        .FRAC_BITS (FILTER_FRACTION_BITS)
    ) u_yaw_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_opcode    (i_opcode),
        .i_x         (w_x_yaw),
        .i_start     (i_start_pressed),
        .i_request   (i_request_yaw),
        .i_dead_zone (r_dead_zone),
        .i_step_size (r_step_size),
        .i_low       (r_yaw_low),
        .i_high      (r_yaw_high),
        .o_result    (w_yaw_res)
    );

    jsp_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_s1_valid),
        .i_pitch         (w_pitch_res),
        .i_yaw           (w_yaw_res),
        .o_ready         (w_merge_ready),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pitch_angle   (o_pitch_angle),
        .o_yaw_angle     (o_yaw_angle),
        .o_pitch_compare (o_pitch_compare),
        .o_yaw_compare   (o_yaw_compare),
        .o_pitch_written (o_pitch_written),
        .o_yaw_written   (o_yaw_written)
    );

endmodule
